// ===== hw/rtl/slpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_pkg
// Shared constants, types and helpers for the length-prefixed packet framer.
// ----------------------------------------------------------------------------
package slpf_pkg;

    // largest frame the block is built for
    localparam int MAX_FRAME_BYTES = 4096;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 12;
    localparam int LIMIT_W = 12;
    localparam int LEN_W   = 16;

    // marker bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA0;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA1;
    localparam logic [BYTE_W-1:0] TERM_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] TERM_LF     = 8'h0A;

    // limit clamp values
    localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = 12'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   =
        (MAX_FRAME_BYTES > 4095) ? 12'd4095 : MAX_FRAME_BYTES[LIMIT_W-1:0];
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd4095;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  byte_position;
        logic              in_packet;
        logic              sync_found;
        logic              packet_good;
        logic              attempt_abort;
    } t_result;

    // effective limit minus one, as used by the abort compare
    function automatic logic [LIMIT_W-1:0] limit_minus_one(input logic [LIMIT_W-1:0] lim);
        logic [LIMIT_W-1:0] eff;
        eff = lim;
        if (eff < LIMIT_FLOOR) begin
            eff = LIMIT_FLOOR;
        end
        if (eff > LIMIT_CAP) begin
            eff = LIMIT_CAP;
        end
        return eff - 12'd1;
    endfunction

endpackage

// ===== hw/rtl/slpf_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_in_stage
// Input register for received bytes; takes a new byte whenever it is empty or
// the held one moves on in the same cycle.
// ----------------------------------------------------------------------------
module slpf_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [slpf_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_valid,
    output logic [slpf_pkg::BYTE_W-1:0] o_byte,
    input  logic                       i_take
);
    import slpf_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/slpf_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpf_framer
// Sync hunt, length capture, terminator check and byte limit, one byte per
// cycle while results are taken, with the result register on the output side.
// ----------------------------------------------------------------------------
module slpf_framer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [slpf_pkg::BYTE_W-1:0]  i_byte,
    output logic                         o_take,
    input  logic [slpf_pkg::LIMIT_W-1:0] i_limit_m1,
    output logic                         o_valid,
    input  logic                         i_ready,
    output slpf_pkg::t_result            o_result
);
    import slpf_pkg::*;

    // framing state
    logic              r_synced;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_prev;
    logic [LEN_W-1:0]  r_len;
    logic              n_synced;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] n_prev;
    logic [LEN_W-1:0]  n_len;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic             sync_hit;
    logic             good;
    logic             over;
    logic             abort_hit;
    logic             pos_nz;
    logic [POS_W:0]   next_pos;
    logic [LEN_W:0]   end_pos;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // byte decision
    always_comb begin
        pos_nz   = (r_pos != '0);
        end_pos  = {1'b0, r_len} + 17'd6;
        next_pos = {1'b0, r_pos} + 13'd1;
        sync_hit = pos_nz && !r_synced && (i_byte == SYNC_SECOND) && (r_prev == SYNC_FIRST);
        good     = pos_nz && r_synced && (i_byte == TERM_LF) && (r_prev == TERM_CR)
                   && ({{(LEN_W-POS_W){1'b0}}, 1'b0, r_pos} == end_pos);
        over      = (next_pos >= {1'b0, i_limit_m1});
        abort_hit = !sync_hit && !good && over;

        // payload length capture
        n_len = r_len;
        if (pos_nz && r_synced && !good) begin
            if (r_pos == 12'd2) begin
                n_len = {i_byte, 8'h00};
            end else if (r_pos == 12'd3) begin
                n_len = {r_len[LEN_W-1:8], i_byte};
            end
        end

        // attempt state
        priority if (sync_hit) begin
            n_synced = 1'b1;
            n_pos    = 12'd2;
            n_prev   = i_byte;
        end else if (good || abort_hit) begin
            n_synced = 1'b0;
            n_pos    = '0;
            n_prev   = '0;
        end else begin
            n_synced = r_synced;
            n_pos    = next_pos[POS_W-1:0];
            n_prev   = i_byte;
        end

        n_out.data_byte     = i_byte;
        n_out.byte_position = sync_hit ? 12'd1 : r_pos;
        n_out.in_packet     = r_synced || sync_hit;
        n_out.sync_found    = sync_hit;
        n_out.packet_good   = good;
        n_out.attempt_abort = abort_hit;
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced    <= 1'b0;
            r_pos       <= '0;
            r_prev      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_synced <= n_synced;
                r_pos    <= n_pos;
                r_prev   <= n_prev;
                r_len    <= n_len;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    // at most one event flag per byte
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> $countones({sync_hit, good, abort_hit}) <= 1)
        else $error("framer event flags overlap");

    // a sync byte always reports position one inside the packet
    a_sync_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sync_found) |-> (r_out.byte_position == 12'd1 && r_out.in_packet))
        else $error("sync byte with wrong position");

    // an ended attempt restarts hunting from position zero
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (good || abort_hit)) |=> (r_pos == '0 && !r_synced && r_prev == '0))
        else $error("attempt not restarted");

    // a good frame ends on a line feed inside a packet
    a_good_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.packet_good) |-> (r_out.data_byte == TERM_LF && r_out.in_packet))
        else $error("good frame without line feed");

endmodule

// ===== hw/rtl/sync_length_packet_framer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_packet_framer_core
// Finds A0 A1 sync, 16-bit length, 0D 0A terminated packets in a byte stream
// and echoes each byte with its position and framing flags.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle and each byte yields exactly one result,
// passing the input register and then the result register; the framing
// decision between them is a few compares and a 13-bit increment, so the
// rate stays at one byte per clock for as long as the output side keeps
// taking results. frame_limit is clamped to 8 at the low end and loaded into
// a register at write time; it should be written only while the stream idles.
// There is no clearing pass after reset.
module sync_length_packet_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [19:8] byte_position, [23:20] zero
    output logic [2:0]  o_m_axis_tuser,   // [0] in_packet, [1] sync_found, [2] attempt_abort
    output logic        o_m_axis_tlast,   // packet_good
    // frame limit write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data        // frame_limit
);
    import slpf_pkg::*;

    logic [LIMIT_W-1:0] r_limit_m1;
    logic               in_valid;
    logic [BYTE_W-1:0]  in_byte;
    logic               take;
    t_result            result;

    assign o_cfg_ready = 1'b1;

    // frame limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_m1 <= limit_minus_one(LIMIT_RESET);
        end else if (i_cfg_valid) begin
            r_limit_m1 <= limit_minus_one(i_cfg_data);
        end
    end

    slpf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (take)
    );

    slpf_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .o_take     (take),
        .i_limit_m1 (r_limit_m1),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    // output packing
    assign o_m_axis_tdata = {4'b0000, result.byte_position, result.data_byte};
    assign o_m_axis_tuser = {result.attempt_abort, result.sync_found, result.in_packet};
    assign o_m_axis_tlast = result.packet_good;

endmodule

// ===== dv/sync_length_packet_framer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_packet_framer_core_tb
// Self-checking bench for the sync-word, length-prefixed packet framer.
// Streams bytes through the core and tracks framing state in a scoreboard.
// Every echoed byte is checked field by field: data, position, in-packet,
// sync, good and abort. The run starts with a short hand-written byte script.
// It then goes through a series of frame limits, small and large, with
// random packets: clean ones, damaged ones and ones with unreachable lengths.
// The byte source pauses in bursts and the result sink applies backpressure.
// ----------------------------------------------------------------------------
module sync_length_packet_framer_core_tb;
    import slpf_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1550;
    localparam int PHASE_BYTES  = 130;

    // framing state tracker and echo scoreboard
    class framer_scoreboard;
        logic [LIMIT_W-1:0] frame_limit;
        bit                 synced;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  last_byte;
        logic [LEN_W-1:0]   length_field;
        t_result            pending_echoes[$];
        int                 failures;
        int                 byte_count;
        int                 sync_count;
        int                 good_count;
        int                 abort_count;

        function new();
            frame_limit  = LIMIT_RESET;
            length_field = '0;
            failures     = 0;
            byte_count   = 0;
            sync_count   = 0;
            good_count   = 0;
            abort_count  = 0;
            start_attempt();
        endfunction

        // back to hunting, previous byte forgotten
        function void start_attempt();
            synced    = 1'b0;
            position  = '0;
            last_byte = '0;
        endfunction

        function void load_limit(logic [LIMIT_W-1:0] value);
            frame_limit = value;
        endfunction

        function bit at_attempt_start();
            return !synced && position == '0;
        endfunction

        function int pending();
            return pending_echoes.size();
        endfunction

        // work out the echo of one accepted byte
        function void accept_byte(logic [BYTE_W-1:0] b);
            t_result echo;
            int      eff;
            int      nxt;
            bit      settled;
            eff = int'(frame_limit);
            if (eff < 8) eff = 8;
            if (eff > MAX_FRAME_BYTES) eff = MAX_FRAME_BYTES;
            echo               = '0;
            echo.data_byte     = b;
            echo.byte_position = position;
            settled            = 1'b0;
            if (position != '0) begin
                if (!synced && b == SYNC_SECOND && last_byte == SYNC_FIRST) begin
                    synced             = 1'b1;
                    echo.sync_found    = 1'b1;
                    echo.byte_position = 12'd1;
                    position           = 12'd2;
                    last_byte          = b;
                    settled            = 1'b1;
                end else if (synced && position >= 12'd4 && b == TERM_LF &&
                             last_byte == TERM_CR &&
                             int'(position) == int'(length_field) + 6) begin
                    echo.packet_good = 1'b1;
                    settled          = 1'b1;
                end else if (synced && position == 12'd2) begin
                    length_field = {b, 8'h00};
                end else if (synced && position == 12'd3) begin
                    length_field[7:0] = b;
                end
            end
            echo.in_packet = synced;
            if (echo.packet_good) begin
                start_attempt();
            end else if (!settled) begin
                nxt = int'(position) + 1;
                if (nxt >= eff - 1) begin
                    echo.attempt_abort = 1'b1;
                    start_attempt();
                end else begin
                    position  = nxt[POS_W-1:0];
                    last_byte = b;
                end
            end
            byte_count++;
            sync_count  += int'(echo.sync_found);
            good_count  += int'(echo.packet_good);
            abort_count += int'(echo.attempt_abort);
            pending_echoes.push_back(echo);
        endfunction

        // compare one echo transaction with the oldest expectation
        function void check_echo(t_result got);
            t_result want;
            if (pending_echoes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected echo: byte=%h pos=%0d pkt=%b sync=%b good=%b abort=%b",
                             got.data_byte, got.byte_position, got.in_packet,
                             got.sync_found, got.packet_good, got.attempt_abort);
                return;
            end
            want = pending_echoes.pop_front();
            if (got.data_byte !== want.data_byte ||
                got.byte_position !== want.byte_position ||
                got.in_packet !== want.in_packet ||
                got.sync_found !== want.sync_found ||
                got.packet_good !== want.packet_good ||
                got.attempt_abort !== want.attempt_abort) begin
                failures++;
                if (failures <= 10)
                    $display({"echo mismatch: expected byte=%h pos=%0d pkt=%b sync=%b good=%b ",
                              "abort=%b, got byte=%h pos=%0d pkt=%b sync=%b good=%b abort=%b"},
                             want.data_byte, want.byte_position, want.in_packet,
                             want.sync_found, want.packet_good, want.attempt_abort,
                             got.data_byte, got.byte_position, got.in_packet,
                             got.sync_found, got.packet_good, got.attempt_abort);
            end
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'h00;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [11:0] cfg_data  = 12'd0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;   // [7:0] data_byte, [19:8] byte_position, [23:20] zero
    logic [2:0]  o_m_axis_tuser;   // [0] in_packet, [1] sync_found, [2] attempt_abort
    logic        o_m_axis_tlast;   // packet_good
    logic        o_cfg_ready;

    framer_scoreboard tracker = new();

    int          idle_cycles    = 0;
    int          bytes_sent     = 0;
    int          burst_left     = 0;
    int          limit_settings = 0;
    int          stall_mode     = 0;
    int          mode_left      = 0;
    logic [7:0]  script[$];
    logic [11:0] limit_plan[$];

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sync_length_packet_framer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // handshakes seen at the rising edge
    wire byte_xfer = rst_n && s_valid && o_s_axis_tready;
    wire echo_xfer = rst_n && o_m_axis_tvalid && m_ready;
    wire cfg_xfer  = rst_n && cfg_valid && o_cfg_ready;

    // echo fields in struct order
    t_result seen_echo;
    assign seen_echo = {o_m_axis_tdata[7:0], o_m_axis_tdata[19:8], o_m_axis_tuser[0],
                        o_m_axis_tuser[1], o_m_axis_tlast, o_m_axis_tuser[2]};

    // monitor: every transaction goes to the scoreboard in a fixed order
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (cfg_xfer) tracker.load_limit(cfg_data);
            if (byte_xfer) tracker.accept_byte(s_data);
            if (echo_xfer) tracker.check_echo(seen_echo);
            idle_cycles <= (cfg_xfer || byte_xfer || echo_xfer) ? 0 : idle_cycles + 1;
        end
    end

    // result sink: backpressure pattern changes every so often
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 4) != 0);
            default: m_ready <= (mode_left[1:0] == 2'd0);
        endcase
    end

    // watchdog on cycles without any transaction
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("stalled for %0d cycles with %0d echoes outstanding",
                 STALL_LIMIT, tracker.pending());
        $display("Some tests failed");
        $finish;
    end

    // one byte transaction, with bursts and gaps on the source side
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    // hold the source off until every echo has come back
    task automatic drain_echoes();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [11:0] value);
        drain_echoes();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    // hunting noise never carries the first sync byte
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == SYNC_FIRST) v = 8'h00;
        return v;
    endfunction

    // payload leans on the marker bytes
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return SYNC_FIRST;
            1:       return SYNC_SECOND;
            2:       return TERM_CR;
            3:       return TERM_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_script();
        foreach (script[i]) send_byte(script[i]);
    endtask

    // one packet with optional leading noise; rough ones may be damaged or
    // carry a length that the limit cannot reach
    task automatic send_frame(input int max_len, input bit rough);
        logic [7:0] frame[$];
        int         noise;
        int         len;
        int         body;
        int         idx;
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (noise) frame.push_back(noise_byte());
        if (rough && $urandom_range(0, 9) == 0) begin
            len  = $urandom_range(0, 65535);
            body = $urandom_range(0, max_len);
        end else begin
            len  = $urandom_range(0, max_len);
            body = len + 1;
        end
        frame.push_back(SYNC_FIRST);
        frame.push_back(SYNC_SECOND);
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);
        repeat (body) frame.push_back(payload_byte());
        frame.push_back(TERM_CR);
        frame.push_back(TERM_LF);
        if (rough && $urandom_range(0, 4) == 0) begin
            idx = $urandom_range(noise + 2, frame.size() - 1);
            case ($urandom_range(0, 3))
                0:       frame.delete(idx);
                1:       frame.insert(idx, payload_byte());
                2:       frame[frame.size() - 1] = noise_byte();
                default: frame[frame.size() - 2] = TERM_LF;
            endcase
        end
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // stimulus
    initial begin
        int          phase;
        int          phase_start;
        int          eff;
        int          max_len;
        logic [11:0] lim;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // reset limit: terminator while hunting, misplaced terminator,
        // sync word inside a packet, then a good packet
        script = '{8'hFF, TERM_CR, TERM_LF, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h03,
                   TERM_CR, TERM_LF, SYNC_FIRST, SYNC_SECOND, TERM_CR, TERM_LF};
        send_script();

        // limit below the floor: sync on the last hunting byte, zero-length
        // packet ending on the limit, abort on a first sync byte and a
        // second sync byte that must not complete it
        write_limit(12'd0);
        script = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, SYNC_FIRST, SYNC_SECOND,
                   8'h00, 8'h00, 8'h55, TERM_CR, TERM_LF,
                   SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'hFF, 8'h11, 8'h22,
                   SYNC_FIRST, SYNC_SECOND};
        send_script();

        // random packets over a series of frame limits
        limit_plan = '{12'd4095, 12'd7, 12'd8, 12'd9, 12'd12, 12'd40, 12'd100,
                       12'd4094, 12'd300, 12'd1, 12'd2048, 12'd64};
        phase = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            // finish the open attempt so a large limit never waits on it
            while (!tracker.at_attempt_start()) send_byte(noise_byte());
            if (phase < limit_plan.size())
                lim = limit_plan[phase];
            else if ($urandom_range(0, 4) == 0)
                lim = 12'($urandom_range(0, 7));
            else
                lim = 12'($urandom_range(8, 4095));
            eff     = (lim < 12'd8) ? 8 : int'(lim);
            max_len = (eff > 40) ? 40 : eff;
            write_limit(lim);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_frame(max_len, eff <= 400);
                if ($urandom_range(0, 24) == 0) drain_echoes();
            end
            phase++;
        end

        drain_echoes();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes over %0d frame limit settings", tracker.byte_count,
                 limit_settings + 1);
        $display("saw %0d sync words, %0d good packets, %0d aborted attempts",
                 tracker.sync_count, tracker.good_count, tracker.abort_count);
        if (tracker.pending() != 0)
            $display("%0d expected echoes never arrived", tracker.pending());
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/slpf_pkg.sv
hw/rtl/slpf_in_stage.sv
hw/rtl/slpf_framer.sv
hw/rtl/sync_length_packet_framer_core.sv
dv/sync_length_packet_framer_core_tb.sv
